// ===== rtl/core/hclm_pkg.sv =====
// ----------------------------------------------------------------------------
// hclm_pkg - shared types and constants for the call-line monitor
// Word layouts, register indexes and line bit positions.
// ----------------------------------------------------------------------------
package hclm_pkg;

  // Line and counter widths
  localparam int LINE_COUNT  = 8;
  localparam int DELAY_WIDTH = 20;
  localparam int AGE_W       = 8;
  localparam int PULSE_W     = 16;
  localparam int CFG_DATA_W  = (DELAY_WIDTH > PULSE_W) ? DELAY_WIDTH : PULSE_W;
  localparam int CFG_IDX_W   = 3;

  // Line bit positions
  localparam int Y1_BIT  = 0;
  localparam int Y1D_BIT = 1;
  localparam int Y2_BIT  = 2;
  localparam int Y2D_BIT = 3;
  localparam int FAN_BIT = 4;
  localparam int PWR_BIT = LINE_COUNT - 1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_WINDOW     = 3'd1,
    REG_RELAY_DLY  = 3'd2,
    REG_PWR_LOSS   = 3'd3,
    REG_ERR_HOLD   = 3'd4
  } hclm_reg_t;

  // Reset values of the registers
  localparam logic [AGE_W-1:0]       DEBOUNCE_RST  = AGE_W'(2);
  localparam logic [AGE_W-1:0]       WINDOW_RST    = AGE_W'(8);
  localparam logic [DELAY_WIDTH-1:0] RELAY_DLY_RST = DELAY_WIDTH'(60000);
  localparam logic [PULSE_W-1:0]     PWR_LOSS_RST  = PULSE_W'(1000);
  localparam logic [PULSE_W-1:0]     ERR_HOLD_RST  = PULSE_W'(15000);

  // Input word
  typedef struct packed {
    logic                  power_fall;
    logic [LINE_COUNT-1:0] line_levels;
    logic                  link_up;
  } hclm_in_t;

  // Result word
  typedef struct packed {
    logic [LINE_COUNT-1:0] led_drive;
    logic                  relay_open;
    logic [LINE_COUNT-1:0] line_state;
    logic                  report_valid;
    logic [LINE_COUNT-1:0] report_mask;
    logic                  power_error;
  } hclm_out_t;

  // Configuration set handed to the step logic
  typedef struct packed {
    logic [AGE_W-1:0]       debounce_ms;
    logic [AGE_W-1:0]       sample_window_ms;
    logic [DELAY_WIDTH-1:0] relay_delay_ms;
    logic [PULSE_W-1:0]     power_loss_ms;
    logic [PULSE_W-1:0]     error_holdoff_ms;
  } hclm_cfg_t;

endpackage

// ===== rtl/core/hclm_cfg.sv =====
// ----------------------------------------------------------------------------
// hclm_cfg - configuration register file
// Five write-only timing registers, loaded by index.
// ----------------------------------------------------------------------------
module hclm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hclm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hclm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hclm_pkg::hclm_cfg_t            cfg
);
  import hclm_pkg::*;

  hclm_cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= DEBOUNCE_RST;
      cfg_r.sample_window_ms <= WINDOW_RST;
      cfg_r.relay_delay_ms   <= RELAY_DLY_RST;
      cfg_r.power_loss_ms    <= PWR_LOSS_RST;
      cfg_r.error_holdoff_ms <= ERR_HOLD_RST;
    end else if (cfg_we) begin
      case (hclm_reg_t'(cfg_index))
        REG_DEBOUNCE:  cfg_r.debounce_ms      <= cfg_wdata[AGE_W-1:0];
        REG_WINDOW:    cfg_r.sample_window_ms <= cfg_wdata[AGE_W-1:0];
        REG_RELAY_DLY: cfg_r.relay_delay_ms   <= cfg_wdata[DELAY_WIDTH-1:0];
        REG_PWR_LOSS:  cfg_r.power_loss_ms    <= cfg_wdata[PULSE_W-1:0];
        REG_ERR_HOLD:  cfg_r.error_holdoff_ms <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/hclm_step.sv =====
// ----------------------------------------------------------------------------
// hclm_step - per-tick monitor logic and its state
// Works out one result word from one tick word; state moves on adv.
// ----------------------------------------------------------------------------
module hclm_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  hclm_pkg::hclm_in_t  tick,
  input  hclm_pkg::hclm_cfg_t cfg,
  output hclm_pkg::hclm_out_t res
);
  import hclm_pkg::*;

  localparam logic [LINE_COUNT-1:0] ALL_LINES = '1;

  // State
  logic                   fall_pending_r, fall_pending_nxt;
  logic [AGE_W-1:0]       fall_age_r, fall_age_nxt;
  logic [PULSE_W-1:0]     pulse_age_r, pulse_age_nxt;
  logic [PULSE_W-1:0]     error_age_r, error_age_nxt;
  logic [DELAY_WIDTH-1:0] fan_age_r, fan_age_nxt;
  logic                   delay_waiting_r, delay_waiting_nxt;
  logic [LINE_COUNT-1:0]  call_state_r, call_state_nxt;
  logic [LINE_COUNT-1:0]  led_r, led_nxt;
  logic                   relay_r, relay_nxt;
  logic                   link_was_up_r, link_was_up_nxt;

  // Intermediate terms
  logic                   arm, pend_a, handle, sample, perr, proc;
  logic [AGE_W-1:0]       age_a;
  logic [LINE_COUNT-1:0]  nstate, changed, led_new, led_a, rep_mask;
  logic                   conn_chg, rep_valid, fan_chg, fan_on;
  logic [DELAY_WIDTH-1:0] fan_age_a;
  logic                   delay_a, relay_a, relay_fire;
  logic [PULSE_W-1:0]     pulse_age_a, pulse_age_b, error_age_a;
  logic                   loss_fire;

  // Fall arming and debounce
  assign arm    = tick.power_fall && !fall_pending_r;
  assign pend_a = fall_pending_r || tick.power_fall;
  assign age_a  = arm ? '0 : fall_age_r;
  assign handle = pend_a && (age_a >= cfg.debounce_ms);
  assign sample = handle && (age_a <= cfg.sample_window_ms);
  assign perr   = sample && tick.line_levels[PWR_BIT] &&
                  (error_age_r > cfg.error_holdoff_ms);
  assign proc   = sample && !perr;

  // Line decode and LED interlock
  assign nstate  = ~tick.line_levels;
  assign changed = nstate ^ call_state_r;
  always_comb begin
    led_new = nstate;
    if (nstate[Y1_BIT] && nstate[Y1D_BIT]) led_new[Y1_BIT] = 1'b0;
    if (nstate[Y2_BIT] && nstate[Y2D_BIT]) led_new[Y2_BIT] = 1'b0;
  end

  // Report
  assign conn_chg  = tick.link_up != link_was_up_r;
  assign rep_valid = proc && tick.link_up && (conn_chg || (changed != '0));
  assign rep_mask  = !rep_valid ? '0 : (conn_chg ? ALL_LINES : changed);

  // Fan relay handling
  assign fan_chg    = proc && changed[FAN_BIT];
  assign fan_on     = nstate[FAN_BIT];
  assign fan_age_a  = (fan_chg && fan_on) ? '0 : fan_age_r;
  assign delay_a    = delay_waiting_r || (fan_chg && fan_on);
  assign relay_a    = (fan_chg && !fan_on) ? 1'b1 : relay_r;
  assign relay_fire = delay_a && (fan_age_a > cfg.relay_delay_ms);

  // Power pulse loss
  assign pulse_age_a = handle ? '0 : pulse_age_r;
  assign led_a       = proc ? led_new : led_r;
  assign loss_fire   = pulse_age_a > cfg.power_loss_ms;
  assign pulse_age_b = loss_fire ? '0 : pulse_age_a;
  assign error_age_a = perr ? '0 : error_age_r;

  // Next state, counters saturate
  always_comb begin
    fall_pending_nxt  = pend_a && !handle;
    fall_age_nxt      = (fall_pending_nxt && !(&age_a)) ? age_a + 1'b1 : age_a;
    pulse_age_nxt     = (&pulse_age_b) ? pulse_age_b : pulse_age_b + 1'b1;
    error_age_nxt     = (&error_age_a) ? error_age_a : error_age_a + 1'b1;
    fan_age_nxt       = (&fan_age_a) ? fan_age_a : fan_age_a + 1'b1;
    delay_waiting_nxt = delay_a && !relay_fire;
    relay_nxt         = relay_a && !relay_fire;
    led_nxt           = loss_fire ? '0 : led_a;
    call_state_nxt    = proc ? nstate : call_state_r;
    link_was_up_nxt   = proc ? tick.link_up : link_was_up_r;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_pending_r  <= 1'b0;
      fall_age_r      <= '0;
      pulse_age_r     <= '0;
      error_age_r     <= '1;
      fan_age_r       <= '0;
      delay_waiting_r <= 1'b0;
      call_state_r    <= '0;
      led_r           <= '0;
      relay_r         <= 1'b0;
      link_was_up_r   <= 1'b0;
    end else if (adv) begin
      fall_pending_r  <= fall_pending_nxt;
      fall_age_r      <= fall_age_nxt;
      pulse_age_r     <= pulse_age_nxt;
      error_age_r     <= error_age_nxt;
      fan_age_r       <= fan_age_nxt;
      delay_waiting_r <= delay_waiting_nxt;
      call_state_r    <= call_state_nxt;
      led_r           <= led_nxt;
      relay_r         <= relay_nxt;
      link_was_up_r   <= link_was_up_nxt;
    end
  end

  // Result word
  assign res.led_drive    = led_nxt;
  assign res.relay_open   = relay_nxt;
  assign res.line_state   = call_state_nxt;
  assign res.report_valid = rep_valid;
  assign res.report_mask  = rep_mask;
  assign res.power_error  = perr;

`ifndef SYNTHESIS
  // A power error always restarts the holdoff
  a_err_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    adv && perr |=> error_age_r == PULSE_W'(1))
    else $error("error age not restarted after power error");

  // A handled fall leaves nothing pending
  a_handle_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && handle |=> !fall_pending_r)
    else $error("fall still pending after being handled");

  // Relays only close when the fan-on delay ends
  a_relay_delay: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(relay_r) |-> !delay_waiting_r)
    else $error("relays closed while fan delay still running");
`endif

endmodule

// ===== rtl/core/hvac_call_line_monitor.sv =====
// ----------------------------------------------------------------------------
// hvac_call_line_monitor - thermostat call-line monitor, one tick per word
// Input register, per-tick step logic, result register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  in_      | in        | in_valid / in_ready  | hclm_in_t (fall, levels, link)
//  out_     | out       | out_valid / out_ready| hclm_out_t (leds, relay, report)
//  cfg_     | in        | cfg_we               | cfg_index, cfg_wdata
//
// One tick word is taken per clock while the output is not stalled; its
// result goes from the input register to the result register. The step
// logic is a single pass of narrow compares and counter increments between
// the two registers.
// Synchronous active-low reset resets both stages and all monitor state.
// A stalled output holds its word; the input register keeps accepting
// until it too is full.
// ----------------------------------------------------------------------------
module hvac_call_line_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hclm_pkg::hclm_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hclm_pkg::hclm_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [hclm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hclm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hclm_pkg::*;

  hclm_cfg_t cfg;
  hclm_in_t  s1_data_r;
  logic      s1_valid_r;
  hclm_out_t res;
  hclm_out_t out_data_r;
  logic      out_valid_r;
  logic      s1_adv;

  // Configuration registers
  hclm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline flow
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Per-tick logic
  hclm_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .tick  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A report always names at least one line
  a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.report_valid |-> out_data_r.report_mask != '0)
    else $error("report raised with empty mask");

  // Power error and status report are exclusive
  a_err_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.power_error |-> !out_data_r.report_valid)
    else $error("report raised together with power error");

  // A word in the input register is never dropped
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register word lost while stalled");
`endif

endmodule
